// ----- rtl/tcgr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

	localparam int DEF_GLYPH_HEIGHT = 16;
	localparam int GLYPH_DEPTH      = 4096;
	localparam int GLYPH_AW         = 12;
	localparam int FIFO_DEPTH       = 4;

	localparam logic [1:0] FUNC_CHAR  = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] REG_BG_COLOR = 2'd0;
	localparam logic [1:0] REG_COLUMNS  = 2'd1;
	localparam logic [1:0] REG_ROWS     = 2'd2;

	localparam logic [31:0] RST_BG_COLOR = 32'h0020_2020;
	localparam logic [7:0]  RST_COLUMNS  = 8'd80;
	localparam logic [6:0]  RST_ROWS     = 7'd25;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// A tab draws four spaces: one glyph plus three more.
	localparam logic [1:0] TAB_EXTRA = 2'd3;

	localparam logic KIND_GLYPH = 1'b0;
	localparam logic KIND_FILL  = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  char_code;
		logic [31:0] color;
		logic [11:0] font_addr;
		logic [7:0]  font_byte;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [10:0] pixel_x;
		logic [10:0] pixel_y;
		logic [7:0]  row_bits;
		logic [31:0] fg_color;
		logic [31:0] bg_color;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        kind;
		logic [10:0] pixel_x;
		logic [10:0] pixel_y;
		logic [31:0] fg_color;
		logic [31:0] bg_color;
		logic        last;
	} meta_t;

	typedef struct packed {
		logic                en;
		logic [GLYPH_AW-1:0] addr;
		logic [7:0]          data;
	} mem_wr_t;

	typedef struct packed {
		logic                en;
		logic [GLYPH_AW-1:0] addr;
	} mem_rd_t;

endpackage

`default_nettype wire

// ----- rtl/text_console_glyph_renderer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Text console glyph renderer.
// Requests arrive on item (item_valid/item_ready): a glyph load writes one byte of
// the glyph memory, a clear homes the cursor and yields one fill result, and a
// character either moves the cursor (newline), does nothing (backspace, NUL) or
// yields one glyph-row result per glyph line (a tab yields four space glyphs).
// Results leave on result (result_valid/result_ready); last marks the final result
// of a request. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while the block is idle; the block does not enforce it.
// Throughput: a drawn character holds the input until all its glyph lines are read
// (a tab four glyphs), one line per cycle through the single glyph memory read
// port while the output queue has room. Loads, newlines, clears and ignored codes
// do not leave idle. Glyph rows and fills are registered in s1 before the queue.
// Results pass through a four-entry output queue; when the receiver stalls the
// queue fills and drawing pauses line by line, so no result is lost.
// Reset clears the cursor and loads the register defaults; the glyph memory is not
// cleared and must be written before the codes that use it are drawn.

module text_console_glyph_renderer
	import tcgr_pkg::*;
#(
	parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire item_t       item,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result
);

	mem_wr_t    wr;
	mem_rd_t    rd;
	logic [7:0] rd_data;
	logic       valid_s1;
	meta_t      meta_s1;
	logic       room;
	result_t    push_data;

	tcgr_ctrl #(
		.GLYPH_HEIGHT(GLYPH_HEIGHT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.room       (room),
		.wr         (wr),
		.rd         (rd),
		.valid_s1   (valid_s1),
		.meta_s1    (meta_s1)
	);

	tcgr_glyph_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_comb begin
		push_data.kind     = meta_s1.kind;
		push_data.pixel_x  = meta_s1.pixel_x;
		push_data.pixel_y  = meta_s1.pixel_y;
		push_data.row_bits = (meta_s1.kind == KIND_FILL) ? 8'd0 : rd_data;
		push_data.fg_color = meta_s1.fg_color;
		push_data.bg_color = meta_s1.bg_color;
		push_data.last     = meta_s1.last;
	end

	tcgr_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (push_data),
		.pending   (valid_s1),
		.room      (room),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (result)
	);

endmodule

`default_nettype wire

// ----- rtl/tcgr_glyph_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcgr_glyph_mem
	import tcgr_pkg::*;
(
	input  wire logic       clk,
	input  wire mem_wr_t    wr,
	input  wire mem_rd_t    rd,
	output logic [7:0]      rd_data
);

	logic [7:0] mem [GLYPH_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tcgr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcgr_ctrl
	import tcgr_pkg::*;
#(
	parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire item_t       item,
	input  wire logic        room,
	output mem_wr_t          wr,
	output mem_rd_t          rd,
	output logic             valid_s1,
	output meta_t            meta_s1
);

	localparam int LINE_W = $clog2(GLYPH_HEIGHT);
	localparam logic [LINE_W-1:0]   LINE_LAST = LINE_W'(GLYPH_HEIGHT - 1);
	localparam logic [GLYPH_AW-1:0] GH_ADDR   = GLYPH_AW'(GLYPH_HEIGHT);
	localparam logic [10:0]         GH_PIX    = 11'(GLYPH_HEIGHT);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DRAW = 2'b10
	} state_t;

	state_t              state_q;
	logic [31:0]         bg_q;
	logic [7:0]          cols_q;
	logic [6:0]          rows_q;
	logic [7:0]          col_q;
	logic [6:0]          row_q;
	logic [LINE_W-1:0]   line_q;
	logic [1:0]          extra_q;
	logic [GLYPH_AW-1:0] base_q;
	logic [31:0]         fg_q;

	logic       acc;
	logic       issue;
	logic       line_done;
	logic [6:0] lim;
	logic [7:0] row_inc;
	logic [6:0] nl_row;
	logic [8:0] col_inc;
	logic       wrap;
	logic       is_char;
	logic       do_nl;
	logic       do_draw;
	logic       do_tab;
	logic       do_clear;

	assign item_ready = (state_q == ST_IDLE) && room;
	assign acc        = item_valid && item_ready;
	assign issue      = (state_q == ST_DRAW) && room;
	assign line_done  = (line_q == LINE_LAST);

	// A row count of zero behaves as one line.
	assign lim     = (rows_q == 7'd0) ? 7'd1 : rows_q;
	assign row_inc = {1'b0, row_q} + 8'd1;
	assign nl_row  = (row_inc >= {1'b0, lim}) ? (lim - 7'd1) : row_inc[6:0];
	assign col_inc = {1'b0, col_q} + 9'd1;
	assign wrap    = (col_inc >= {1'b0, cols_q});

	always_comb begin
		is_char  = acc && (item.func == FUNC_CHAR);
		do_clear = acc && (item.func == FUNC_CLEAR);
		do_nl    = is_char && (item.char_code == CH_NL);
		do_tab   = is_char && (item.char_code == CH_TAB);
		do_draw  = is_char && !(item.char_code inside {CH_NUL, CH_BS, CH_NL});
	end

	assign wr.en   = acc && (item.func == FUNC_LOAD);
	assign wr.addr = item.font_addr;
	assign wr.data = item.font_byte;

	assign rd.en   = issue;
	assign rd.addr = base_q + GLYPH_AW'(line_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q   <= RST_BG_COLOR;
			cols_q <= RST_COLUMNS;
			rows_q <= RST_ROWS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BG_COLOR: bg_q   <= cfg_data;
				REG_COLUMNS:  cols_q <= cfg_data[7:0];
				REG_ROWS:     rows_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			col_q    <= 8'd0;
			row_q    <= 7'd0;
			line_q   <= '0;
			extra_q  <= 2'd0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue || do_clear;
			case (state_q)
				ST_IDLE: begin
					if (do_clear) begin
						col_q <= 8'd0;
						row_q <= 7'd0;
					end else if (do_nl) begin
						col_q <= 8'd0;
						row_q <= nl_row;
					end else if (do_draw) begin
						state_q <= ST_DRAW;
						line_q  <= '0;
						extra_q <= do_tab ? TAB_EXTRA : 2'd0;
					end
				end
				ST_DRAW: begin
					if (issue) begin
						if (line_done) begin
							line_q <= '0;
							// The cursor moves once per drawn glyph.
							if (wrap) begin
								col_q <= 8'd0;
								row_q <= nl_row;
							end else begin
								col_q <= col_inc[7:0];
							end
							if (extra_q == 2'd0) begin
								state_q <= ST_IDLE;
							end else begin
								extra_q <= extra_q - 2'd1;
							end
						end else begin
							line_q <= line_q + LINE_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_draw) begin
			fg_q   <= item.color;
			base_q <= (do_tab ? GLYPH_AW'(CH_SPACE) : GLYPH_AW'(item.char_code)) * GH_ADDR;
		end
		if (do_clear) begin
			meta_s1.kind     <= KIND_FILL;
			meta_s1.pixel_x  <= 11'd0;
			meta_s1.pixel_y  <= 11'd0;
			meta_s1.fg_color <= 32'd0;
			meta_s1.bg_color <= item.color;
			meta_s1.last     <= 1'b1;
		end else begin
			meta_s1.kind     <= KIND_GLYPH;
			meta_s1.pixel_x  <= {col_q, 3'b000};
			meta_s1.pixel_y  <= 11'(row_q) * GH_PIX + 11'(line_q);
			meta_s1.fg_color <= fg_q;
			meta_s1.bg_color <= bg_q;
			meta_s1.last     <= line_done && (extra_q == 2'd0);
		end
	end

	a_draw_ends: assert property (@(posedge clk) disable iff (!arst_n)
		issue && line_done && (extra_q == 2'd0) |=> state_q == ST_IDLE)
		else $error("glyph sequence did not return to idle after its last line");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (item.func == FUNC_LOAD) |=> (state_q == ST_IDLE) && !valid_s1)
		else $error("glyph load produced a result or left idle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) && !room |=>
			$stable(line_q) && $stable(col_q) && $stable(row_q))
		else $error("drawing advanced while the output queue had no room");

	a_fill_home: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (meta_s1.kind == KIND_FILL) |->
			(col_q == 8'd0) && (row_q == 7'd0) && meta_s1.last)
		else $error("fill result without the cursor at home");

endmodule

`default_nettype wire

// ----- rtl/tcgr_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcgr_out_fifo
	import tcgr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	input  wire logic    pending,
	output logic         room,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	result_t            entries_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign out_valid = (count_q != '0);
	assign out_data  = entries_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Room is judged with the read already in flight counted as queued.
	assign room = ((CNT_W + 1)'(count_q) + (CNT_W + 1)'(pending)) < (CNT_W + 1)'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_W'(FIFO_DEPTH)) || pop)
		else $error("result pushed into a full output queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("output queue count out of range");

endmodule

`default_nettype wire
